@@ design/vgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_pkg: shared constants and types of the VGM PSG command player
// Command opcodes, register map, sizes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package vgm_pkg;

  // Sizes
  localparam int ADDR_WIDTH = 16;
  localparam int MAX_RUN    = 32;
  localparam int RUN_CAP    = (MAX_RUN < 32) ? MAX_RUN : 32;
  localparam int RUN_W      = (RUN_CAP > 1) ? $clog2(RUN_CAP) : 1;
  localparam int MEM_DEPTH  = 1 << ADDR_WIDTH;
  localparam int WAIT_W     = 17;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // Command bytes
  localparam logic [7:0] CMD_SKIP2      = 8'h4F;
  localparam logic [7:0] CMD_PSG        = 8'h50;
  localparam logic [7:0] CMD_WAIT_ARG   = 8'h61;
  localparam logic [7:0] CMD_WAIT_SHORT = 8'h62;
  localparam logic [7:0] CMD_WAIT_LONG  = 8'h63;
  localparam logic [7:0] CMD_END        = 8'h66;

  // Reset values
  localparam logic [15:0] LOOP_RESET  = 16'h006B;
  localparam logic [15:0] START_RESET = 16'h0040;
  localparam logic [15:0] SHORT_RESET = 16'd4;
  localparam logic [15:0] LONG_RESET  = 16'd9;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_LOOP_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SHORT_WAIT   = 2'd1;
  localparam logic [1:0] REG_LONG_WAIT    = 2'd2;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_P1,
    RD_PTR_P2
  } rd_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ADD1,
    PTR_ADD2,
    PTR_ADD3,
    PTR_LOOP
  } ptr_op_t;

  typedef enum logic [1:0] {
    WAIT_HOLD,
    WAIT_DEC,
    WAIT_ADD_SHORT,
    WAIT_ADD_LONG
  } wait_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     mem_we;
    logic     rd_en;
    rd_sel_t  rd_sel;
    ptr_op_t  ptr_op;
    wait_op_t wait_op;
    logic     latch_data;
    logic     emit;
    logic     emit_write;
    logic     emit_last;
    logic     run_clr;
    logic     run_inc;
  } vgm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic       wait_zero;
    logic [7:0] rdata;
    logic       slot_free;
    logic       run_last;
  } vgm_sts_t;

endpackage

@@ design/vgm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_if: request and result channels of the VGM PSG command player
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface vgm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] load_address;
  logic [7:0]  load_data;

  modport source (output valid, req_type, load_address, load_data, input ready);
  modport sink   (input valid, req_type, load_address, load_data, output ready);
endinterface

interface vgm_res_if;
  logic        valid;
  logic        ready;
  logic        psg_write_valid;
  logic [7:0]  psg_data;
  logic        last_of_tick;
  logic [15:0] play_position;

  modport source (output valid, psg_write_valid, psg_data, last_of_tick, play_position,
                  input ready);
  modport sink   (input valid, psg_write_valid, psg_data, last_of_tick, play_position,
                  output ready);
endinterface

@@ design/vgm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_ctrl: command sequencer of the VGM PSG command player
// Takes loads into memory and steps each tick through wait countdown, command fetch, decode and PSG runs.
// ----------------------------------------------------------------------------
module vgm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  vgm_pkg::vgm_sts_t  sts,
  output vgm_pkg::vgm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAITDEC,
    S_CMD,
    S_DATA,
    S_PEEK,
    S_NOWR
  } state_t;

  state_t state;
  state_t state_next;
  logic   more;

  // Another write follows in this tick
  assign more = (sts.rdata == vgm_pkg::CMD_PSG) && !sts.run_last;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode state into datapath commands
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = vgm_pkg::RD_PTR;
    cmd.ptr_op     = vgm_pkg::PTR_HOLD;
    cmd.wait_op    = vgm_pkg::WAIT_HOLD;
    state_next     = state;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.req_valid) begin
          if (sts.req_type == vgm_pkg::REQ_LOAD) begin
            cmd.mem_we = 1'b1;
          end else if (sts.wait_zero) begin
            cmd.rd_en  = 1'b1;
            state_next = S_CMD;
          end else begin
            state_next = S_WAITDEC;
          end
        end
      end
      S_WAITDEC: begin
        if (sts.slot_free) begin
          cmd.wait_op   = vgm_pkg::WAIT_DEC;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CMD: begin
        state_next = S_NOWR;
        case (sts.rdata)
          vgm_pkg::CMD_PSG: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = vgm_pkg::RD_PTR_P1;
            state_next = S_DATA;
          end
          vgm_pkg::CMD_SKIP2:    cmd.ptr_op = vgm_pkg::PTR_ADD2;
          vgm_pkg::CMD_WAIT_ARG: cmd.ptr_op = vgm_pkg::PTR_ADD3;
          vgm_pkg::CMD_WAIT_SHORT: begin
            cmd.ptr_op  = vgm_pkg::PTR_ADD1;
            cmd.wait_op = vgm_pkg::WAIT_ADD_SHORT;
          end
          vgm_pkg::CMD_WAIT_LONG: begin
            cmd.ptr_op  = vgm_pkg::PTR_ADD1;
            cmd.wait_op = vgm_pkg::WAIT_ADD_LONG;
          end
          vgm_pkg::CMD_END:      cmd.ptr_op = vgm_pkg::PTR_LOOP;
          default:               cmd.ptr_op = vgm_pkg::PTR_ADD1;
        endcase
      end
      S_DATA: begin
        // Capture the data byte, step over the command, peek the next one
        cmd.latch_data = 1'b1;
        cmd.ptr_op     = vgm_pkg::PTR_ADD2;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = vgm_pkg::RD_PTR_P2;
        state_next     = S_PEEK;
      end
      S_PEEK: begin
        if (sts.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_write = 1'b1;
          cmd.emit_last  = !more;
          if (more) begin
            cmd.run_inc = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = vgm_pkg::RD_PTR_P1;
            state_next  = S_DATA;
          end else begin
            cmd.run_clr = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_NOWR: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free)
    else $error("result loaded while output register is occupied");

  a_wait_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.wait_op == vgm_pkg::WAIT_DEC) |-> !sts.wait_zero)
    else $error("wait decremented below zero");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && sts.req_valid && sts.req_type == vgm_pkg::REQ_TICK)
      |=> (state != S_IDLE))
    else $error("tick accepted without leaving idle");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.run_inc |-> !sts.run_last)
    else $error("run counter stepped past the cap");
`endif

endmodule

@@ design/vgm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_dp: datapath of the VGM PSG command player
// Music memory, play pointer, wait counter, registers and output register.
// ----------------------------------------------------------------------------
module vgm_dp (
  input  logic                          clk,
  input  logic                          rst,
  vgm_req_if.sink                       req,
  vgm_res_if.source                     res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vgm_pkg::PADDR_W-1:0]   paddr,
  input  logic [vgm_pkg::PDATA_W-1:0]   pwdata,
  output logic [vgm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  vgm_pkg::vgm_cmd_t             cmd,
  output vgm_pkg::vgm_sts_t             sts
);

  logic [7:0]                      mem [vgm_pkg::MEM_DEPTH];
  logic [7:0]                      rdata;
  logic [vgm_pkg::ADDR_WIDTH-1:0]  rd_addr;
  logic [vgm_pkg::ADDR_WIDTH-1:0]  ptr;
  logic [vgm_pkg::WAIT_W-1:0]      wait_cnt;
  logic [vgm_pkg::WAIT_W:0]        wait_sum;
  logic [15:0]                     wait_add;
  logic [vgm_pkg::RUN_W-1:0]       run_cnt;
  logic [7:0]                      data_hold;
  logic [15:0]                     loop_address;
  logic [15:0]                     short_wait_ticks;
  logic [15:0]                     long_wait_ticks;
  logic                            cfg_we;
  logic                            out_valid;
  logic                            slot_free;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_address     <= vgm_pkg::LOOP_RESET;
      short_wait_ticks <= vgm_pkg::SHORT_RESET;
      long_wait_ticks  <= vgm_pkg::LONG_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        vgm_pkg::REG_LOOP_ADDRESS: loop_address     <= pwdata[15:0];
        vgm_pkg::REG_SHORT_WAIT:   short_wait_ticks <= pwdata[15:0];
        vgm_pkg::REG_LONG_WAIT:    long_wait_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vgm_pkg::REG_LOOP_ADDRESS: prdata = {16'b0, loop_address};
      vgm_pkg::REG_SHORT_WAIT:   prdata = {16'b0, short_wait_ticks};
      vgm_pkg::REG_LONG_WAIT:    prdata = {16'b0, long_wait_ticks};
      default:                   prdata = '0;
    endcase
  end

  // Select the memory read address
  always_comb begin
    case (cmd.rd_sel)
      vgm_pkg::RD_PTR_P1: rd_addr = ptr + vgm_pkg::ADDR_WIDTH'(1);
      vgm_pkg::RD_PTR_P2: rd_addr = ptr + vgm_pkg::ADDR_WIDTH'(2);
      default:            rd_addr = ptr;
    endcase
  end

  // Music memory: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[vgm_pkg::ADDR_WIDTH'(req.load_address)] <= req.load_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Advance the play pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= vgm_pkg::ADDR_WIDTH'(vgm_pkg::START_RESET);
    end else begin
      case (cmd.ptr_op)
        vgm_pkg::PTR_ADD1: ptr <= ptr + vgm_pkg::ADDR_WIDTH'(1);
        vgm_pkg::PTR_ADD2: ptr <= ptr + vgm_pkg::ADDR_WIDTH'(2);
        vgm_pkg::PTR_ADD3: ptr <= ptr + vgm_pkg::ADDR_WIDTH'(3);
        vgm_pkg::PTR_LOOP: ptr <= vgm_pkg::ADDR_WIDTH'(loop_address);
        default: ;
      endcase
    end
  end

  // Saturating wait add
  assign wait_add = (cmd.wait_op == vgm_pkg::WAIT_ADD_LONG) ? long_wait_ticks
                                                             : short_wait_ticks;
  assign wait_sum = {1'b0, wait_cnt} + (vgm_pkg::WAIT_W + 1)'(wait_add);

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_cnt <= '0;
    end else begin
      case (cmd.wait_op)
        vgm_pkg::WAIT_DEC: wait_cnt <= wait_cnt - vgm_pkg::WAIT_W'(1);
        vgm_pkg::WAIT_ADD_SHORT, vgm_pkg::WAIT_ADD_LONG: begin
          wait_cnt <= wait_sum[vgm_pkg::WAIT_W] ? vgm_pkg::WAIT_MAX
                                                : wait_sum[vgm_pkg::WAIT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Count writes of the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (cmd.run_clr) begin
      run_cnt <= '0;
    end else if (cmd.run_inc) begin
      run_cnt <= run_cnt + vgm_pkg::RUN_W'(1);
    end
  end

  // Hold the PSG data byte
  always_ff @(posedge clk) begin
    if (cmd.latch_data) begin
      data_hold <= rdata;
    end
  end

  // Output register
  assign slot_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.psg_write_valid <= cmd.emit_write;
      res.psg_data        <= cmd.emit_write ? data_hold : 8'h00;
      res.last_of_tick    <= cmd.emit_last;
      res.play_position   <= 16'(ptr);
    end
  end

  assign res.valid = out_valid;
  assign req.ready = cmd.in_ready;

  // Status toward the controller
  assign sts.req_valid = req.valid;
  assign sts.req_type  = req.req_type;
  assign sts.wait_zero = (wait_cnt == '0);
  assign sts.rdata     = rdata;
  assign sts.slot_free = slot_free;
  assign sts.run_last  = (run_cnt == vgm_pkg::RUN_W'(vgm_pkg::RUN_CAP - 1));

endmodule

@@ design/vgm_psg_command_player.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_psg_command_player: VGM command stream player for a PSG sound chip
// Holds the music in an on-chip memory and turns ticks into PSG port writes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per item: req_type 0 stores load_data at
//   load_address (no result), req_type 1 is one playback tick.
//   res returns the results of a tick: one beat per PSG write, or a single
//   beat without a write; last_of_tick marks the final beat of the tick.
//   The APB port sets the loop address and the two wait lengths; write it
//   only while no tick is in flight.
// Flow:
//   A load is written straight into the memory. A wait countdown tick
//   reads no memory; a non-PSG command needs a command fetch, and a run
//   of PSG writes a command fetch, then a data fetch and a peek at the next
//   command per write, as the music memory has a single registered read
//   port. One item is worked on at a time; a new item is accepted once the
//   previous tick has loaded its last result into the output register.
// Reset: play position 0x40, no pending wait, registers at defaults; the
//   memory content is undefined until loaded.
// Stall: while res is not taken the sequencer holds its next result; req
//   keeps taking loads and at most one more tick, then stays not ready.
// ----------------------------------------------------------------------------
module vgm_psg_command_player (
  input  logic                          clk,
  input  logic                          rst,
  vgm_req_if.sink                       req,
  vgm_res_if.source                     res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vgm_pkg::PADDR_W-1:0]   paddr,
  input  logic [vgm_pkg::PDATA_W-1:0]   pwdata,
  output logic [vgm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  vgm_pkg::vgm_cmd_t cmd;
  vgm_pkg::vgm_sts_t sts;

  // Sequencer
  vgm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Storage and arithmetic
  vgm_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
